// ===== rtl/dco_frequency_lock_controller_core_assert.svh =====
// Assertion macros used by the checker file of the frequency-lock controller.
`ifndef DCO_FREQUENCY_LOCK_CONTROLLER_CORE_ASSERT_SVH
`define DCO_FREQUENCY_LOCK_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frequency-lock controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define DFLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frequency-lock controller check failed");

`endif

// ===== rtl/dflc_pkg.sv =====
package dflc_pkg;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_REGULATE,
		OP_RESTART,
		OP_SAFE_RESTART
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIVIDE,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic signed [11:0] err;
		logic [15:0]        sdiff;
	} front_item_t;

	localparam logic [1:0] REINIT_NONE    = 2'd0;
	localparam logic [1:0] REINIT_RESTART = 2'd1;

	localparam logic [1:0] CFG_RATIO  = 2'd0;
	localparam logic [1:0] CFG_COARSE = 2'd1;
	localparam logic [1:0] CFG_FINE   = 2'd2;

	localparam logic [15:0] RATIO_RESET  = 16'd128;
	localparam logic [14:0] COARSE_RESET = 15'd174;
	localparam logic [14:0] FINE_RESET   = 15'd4;

	localparam logic [15:0]        MIN_INTERVAL = 16'd16;
	localparam logic signed [11:0] ERR_MIN      = -12'sd2048;
	localparam logic signed [11:0] ERR_MAX      = 12'sd2047;
	localparam logic signed [16:0] DEV_REINIT   = -17'sd32767;

	localparam logic [7:0] RESET_TAP   = 8'h60;
	localparam logic [2:0] RESET_RANGE = 3'd4;
	localparam logic [7:0] SAFE_TAP    = 8'h80;
	localparam logic [2:0] SAFE_RANGE  = 3'd6;
	localparam logic [7:0] TAP_STEP    = 8'h20;
	localparam logic [7:0] TAP_LIMIT   = 8'hE0;
	localparam logic [2:0] RANGE_MAX   = 3'd7;

	localparam logic [3:0] DIV_LAST = 4'd15;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam logic [QAW:0] QCOUNT_FULL = (QAW + 1)'(QDEPTH);

endpackage

// ===== rtl/dco_frequency_lock_controller_core.sv =====
// Frequency-lock controller for a digitally controlled oscillator.
// Sync events come in on a queue-style channel: an item (fast count, slow count,
// reinit mode) is taken at a clock edge with push high and full low. Every item
// gives exactly one result, shown on the result ports while empty is low and
// taken at an edge with pop high.
// The front stage registers the intervals, then the slow one times the ratio,
// forms the saturated error and places the item in a two-entry queue; it takes
// one item per cycle until its stages and the queue are full.
// The back stage carries items out in order. A hold or reinit item is handled in
// the idle state and loads the output register directly. A regulating item
// goes through a restoring divider that settles one quotient bit per cycle,
// then a finish state loads the result; no new item is taken before that.
// When pop stays low the result waits in the output register, the back stage
// stops once it has a further result ready, and full rises when the queue and
// the front stages have filled.
// Reset empties every stage, clears the stored counts, restores the default
// registers, reset oscillator setting and reinit deviation. Registers are written
// via cfg_write, cfg_index, cfg_data, only while idle: a user's duty, unchecked.
module dco_frequency_lock_controller_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [31:0]        fast_count,
	input  logic [15:0]        slow_count,
	input  logic [1:0]         reinit_mode,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] deviation,
	output logic [7:0]         dco_setting,
	output logic [2:0]         range_select,
	output logic               measured,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import dflc_pkg::*;

	logic [15:0] ratio_q;
	logic [14:0] coarse_q;
	logic [14:0] fine_q;
	logic        f_valid;
	front_item_t f_item;
	logic        q_full;
	logic        b_valid;
	front_item_t b_item;
	logic        b_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			coarse_q <= COARSE_RESET;
			fine_q   <= FINE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RATIO: begin
					ratio_q <= cfg_data;
				end
				CFG_COARSE: begin
					coarse_q <= cfg_data[14:0];
				end
				CFG_FINE: begin
					fine_q <= cfg_data[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	dflc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.fast_count  (fast_count),
		.slow_count  (slow_count),
		.reinit_mode (reinit_mode),
		.ratio       (ratio_q),
		.item_valid  (f_valid),
		.item        (f_item),
		.item_full   (q_full)
	);

	dflc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_item  (f_item),
		.wr_full  (q_full),
		.rd_valid (b_valid),
		.rd_item  (b_item),
		.rd_pop   (b_pop)
	);

	dflc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (b_valid),
		.q_item       (b_item),
		.q_pop        (b_pop),
		.coarse_limit (coarse_q),
		.fine_limit   (fine_q),
		.empty        (empty),
		.pop          (pop),
		.deviation    (deviation),
		.dco_setting  (dco_setting),
		.range_select (range_select),
		.measured     (measured)
	);

endmodule

// ===== rtl/dflc_front.sv =====
module dflc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [31:0]           fast_count,
	input  logic [15:0]           slow_count,
	input  logic [1:0]            reinit_mode,
	input  logic [15:0]           ratio,
	output logic                  item_valid,
	output dflc_pkg::front_item_t item,
	input  logic                  item_full
);
	import dflc_pkg::*;

	logic [31:0]        prev_fast_q;
	logic [15:0]        prev_slow_q;
	logic [31:0]        fdiff;
	logic [15:0]        sdiff;
	op_t                op_d;
	logic               accept;
	logic               valid_s1;
	op_t                op_s1;
	logic [31:0]        fdiff_s1;
	logic [15:0]        sdiff_s1;
	logic               valid_s2;
	op_t                op_s2;
	logic [31:0]        fdiff_s2;
	logic [15:0]        sdiff_s2;
	logic [31:0]        prod_s2;
	logic [31:0]        err_raw;
	logic signed [11:0] err_sat;
	logic               s1_move;
	logic               s2_move;
	logic               s1_ready;
	logic               s2_ready;

	assign fdiff = fast_count - prev_fast_q;
	assign sdiff = slow_count - prev_slow_q;

	always_comb begin
		case (reinit_mode)
			REINIT_NONE: begin
				op_d = (sdiff >= MIN_INTERVAL) ? OP_REGULATE : OP_HOLD;
			end
			REINIT_RESTART: begin
				op_d = OP_RESTART;
			end
			default: begin
				op_d = OP_SAFE_RESTART;
			end
		endcase
	end

	assign s2_move  = valid_s2 && !item_full;
	assign s2_ready = !valid_s2 || s2_move;
	assign s1_move  = valid_s1 && s2_ready;
	assign s1_ready = !valid_s1 || s1_move;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_fast_q <= '0;
			prev_slow_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (accept && op_d != OP_HOLD) begin
				prev_fast_q <= fast_count;
				prev_slow_q <= slow_count;
			end
			if (s1_ready) begin
				valid_s1 <= push;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_d;
			fdiff_s1 <= fdiff;
			sdiff_s1 <= sdiff;
		end
		if (s1_move) begin
			op_s2    <= op_s1;
			fdiff_s2 <= fdiff_s1;
			sdiff_s2 <= sdiff_s1;
			prod_s2  <= 32'(sdiff_s1) * 32'(ratio);
		end
	end

	assign err_raw = fdiff_s2 - prod_s2;

	always_comb begin
		if (err_raw[31] && !(&err_raw[30:11])) begin
			err_sat = ERR_MIN;
		end else if (!err_raw[31] && (|err_raw[30:11])) begin
			err_sat = ERR_MAX;
		end else begin
			err_sat = $signed(err_raw[11:0]);
		end
	end

	assign item_valid = valid_s2;
	assign item.op    = op_s2;
	assign item.err   = err_sat;
	assign item.sdiff = sdiff_s2;

endmodule

// ===== rtl/dflc_queue.sv =====
module dflc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	input  dflc_pkg::front_item_t wr_item,
	output logic                  wr_full,
	output logic                  rd_valid,
	output dflc_pkg::front_item_t rd_item,
	input  logic                  rd_pop
);
	import dflc_pkg::*;

	front_item_t    mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           wr_en;
	logic           rd_en;

	assign wr_full  = (count_q == QCOUNT_FULL);
	assign rd_valid = (count_q != '0);
	assign wr_en    = wr_valid && !wr_full;
	assign rd_en    = rd_pop && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/dflc_back.sv =====
module dflc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  dflc_pkg::front_item_t q_item,
	output logic                  q_pop,
	input  logic [14:0]           coarse_limit,
	input  logic [14:0]           fine_limit,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [15:0]    deviation,
	output logic [7:0]            dco_setting,
	output logic [2:0]            range_select,
	output logic                  measured
);
	import dflc_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [7:0]         tap_q;
	logic [2:0]         range_q;
	logic signed [16:0] dev_q;
	logic [16:0]        rem_q;
	logic [15:0]        quo_q;
	logic [15:0]        divisor_q;
	logic [3:0]         cnt_q;
	logic               neg_q;
	logic               out_valid_q;
	logic [15:0]        out_dev_q;
	logic [7:0]         out_tap_q;
	logic [2:0]         out_range_q;
	logic               out_meas_q;

	logic               slot_free;
	logic               out_load;
	logic               load_div;
	logic [7:0]         nxt_tap;
	logic [2:0]         nxt_range;
	logic signed [16:0] nxt_dev;
	logic               nxt_meas;
	logic [16:0]        shifted;
	logic               fits;
	logic signed [15:0] num;
	logic [15:0]        num_mag;
	logic [15:0]        div_mag;
	logic signed [16:0] dev_div;
	logic signed [16:0] cl_s;
	logic signed [16:0] fl_s;
	logic signed [16:0] neg_cl;
	logic signed [16:0] neg_fl;
	logic [7:0]         reg_tap;
	logic [2:0]         reg_range;

	assign slot_free = !out_valid_q || pop;

	assign num     = {q_item.err, 4'b0000};
	assign num_mag = num[15] ? 16'(-num) : num;
	assign div_mag = q_item.sdiff[15] ? 16'(-q_item.sdiff) : q_item.sdiff;

	assign shifted = {rem_q[15:0], quo_q[15]};
	assign fits    = (shifted >= {1'b0, divisor_q});
	assign dev_div = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	assign cl_s   = $signed({2'b00, coarse_limit});
	assign fl_s   = $signed({2'b00, fine_limit});
	assign neg_cl = -cl_s;
	assign neg_fl = -fl_s;

	always_comb begin
		reg_tap   = tap_q;
		reg_range = range_q;
		if (dev_div > cl_s) begin
			if (tap_q[7:5] != 3'd0) begin
				reg_tap = tap_q - TAP_STEP;
			end else if (tap_q != 8'd0) begin
				reg_tap = 8'd0;
			end else if (range_q != 3'd0) begin
				reg_range = range_q - 3'd1;
				reg_tap   = SAFE_TAP;
			end
		end else if (dev_div > fl_s) begin
			if (tap_q != 8'd0) begin
				reg_tap = tap_q - 8'd1;
			end else if (range_q != 3'd0) begin
				reg_range = range_q - 3'd1;
				reg_tap   = SAFE_TAP;
			end
		end else if (dev_div < neg_cl) begin
			if (tap_q < TAP_LIMIT) begin
				reg_tap = tap_q + TAP_STEP;
			end else if (range_q < RANGE_MAX) begin
				reg_range = range_q + 3'd1;
				reg_tap   = SAFE_TAP;
			end
		end else if (dev_div < neg_fl) begin
			if (tap_q < TAP_LIMIT) begin
				reg_tap = tap_q + 8'd1;
			end else if (range_q < RANGE_MAX) begin
				reg_range = range_q + 3'd1;
				reg_tap   = SAFE_TAP;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		load_div  = 1'b0;
		nxt_tap   = tap_q;
		nxt_range = range_q;
		nxt_dev   = dev_q;
		nxt_meas  = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						OP_REGULATE: begin
							q_pop    = 1'b1;
							load_div = 1'b1;
							state_d  = BK_DIVIDE;
						end
						OP_HOLD: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								out_load = 1'b1;
								nxt_meas = 1'b0;
							end
						end
						OP_RESTART: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								out_load = 1'b1;
								nxt_dev  = DEV_REINIT;
							end
						end
						OP_SAFE_RESTART: begin
							if (slot_free) begin
								q_pop     = 1'b1;
								out_load  = 1'b1;
								nxt_dev   = DEV_REINIT;
								nxt_tap   = SAFE_TAP;
								nxt_range = SAFE_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_DIVIDE: begin
				if (cnt_q == DIV_LAST) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (slot_free) begin
					out_load  = 1'b1;
					nxt_dev   = dev_div;
					nxt_tap   = reg_tap;
					nxt_range = reg_range;
					state_d   = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			tap_q       <= RESET_TAP;
			range_q     <= RESET_RANGE;
			dev_q       <= DEV_REINIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				tap_q       <= nxt_tap;
				range_q     <= nxt_range;
				dev_q       <= nxt_dev;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q     <= '0;
			quo_q     <= num_mag;
			divisor_q <= div_mag;
			neg_q     <= num[15] ^ q_item.sdiff[15];
			cnt_q     <= '0;
		end else if (state_q == BK_DIVIDE) begin
			rem_q <= fits ? (shifted - {1'b0, divisor_q}) : shifted;
			quo_q <= {quo_q[14:0], fits};
			cnt_q <= cnt_q + 4'd1;
		end
		if (out_load) begin
			out_dev_q   <= nxt_dev[15:0];
			out_tap_q   <= nxt_tap;
			out_range_q <= nxt_range;
			out_meas_q  <= nxt_meas;
		end
	end

	assign empty        = !out_valid_q;
	assign deviation    = $signed(out_dev_q);
	assign dco_setting  = out_tap_q;
	assign range_select = out_range_q;
	assign measured     = out_meas_q;

endmodule

// ===== rtl/dflc_checker.sv =====
`include "dco_frequency_lock_controller_core_assert.svh"

module dflc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic signed [15:0] deviation,
	input logic [7:0]         dco_setting,
	input logic [2:0]         range_select,
	input logic               measured
);

	`DFLC_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty)
	`DFLC_ASSERT_NEXT(a_result_stable, clk, arst_n, !empty && !pop,
		$stable(deviation) && $stable(dco_setting) && $stable(range_select) && $stable(measured))
	`DFLC_ASSERT_SAME(a_full_after_accept, clk, arst_n, $rose(full), $past(push && !full))
	`DFLC_ASSERT_NEXT(a_reset_clears, clk, 1'b1, !arst_n, empty && !full)

endmodule

bind dco_frequency_lock_controller_core dflc_checker u_dflc_checker (.*);
